[rtl/core/float_fixed_converter_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the converter
// Shared assertion forms, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef FLOAT_FIXED_CONVERTER_TOP_MACROS_SVH
`define FLOAT_FIXED_CONVERTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFC_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FFC_ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

[rtl/core/ffc_pkg.sv]
// ----------------------------------------------------------------------------
// ffc_pkg
// Types and constants for the float / fixed converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ffc_pkg;
    localparam int FRACTION_BITS_DEF = 8;

    typedef enum logic [1:0] {
        FUNC_INT2FIX = 2'd0,
        FUNC_FLT2FIX = 2'd1,
        FUNC_FIX2FLT = 2'd2,
        FUNC_FIX2INT = 2'd3
    } t_func;

    localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_SAT = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] result;
        logic        overflow;
    } t_res;
endpackage

[rtl/core/float_fixed_converter_top.sv]
// ----------------------------------------------------------------------------
// float_fixed_converter_top
// Float / integer / fixed-point converter, one item per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with i_func and i_operand; the item is taken when busy
//   is low, and busy is always low, so an item may enter every cycle.
//   The item is registered in r_func / r_op, converted in one combinational
//   pass, and the result register r_res shows o_result / o_overflow with
//   o_done high for one cycle. Throughput: 1 item per cycle, set by the
//   single conversion pass between the input and result registers.
//   Reset clears the valid flags; no item is in flight after reset.
//   The receiver cannot stall; results must be taken when o_done is high.
//   func: 0 int to fixed, 1 float to fixed, 2 fixed to float,
//   3 fixed to int. o_overflow marks a saturated result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "float_fixed_converter_top_macros.svh"
module float_fixed_converter_top import ffc_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_operand,
    output logic        o_done,
    output logic [31:0] o_result,
    output logic        o_overflow
);
    logic        r_in_vld, r_out_vld;
    t_func       r_func;
    logic [31:0] r_op;
    t_res        r_res, n_res;

    assign busy = 1'b0;

    ffc_conv #(.FRACTION_BITS(FRACTION_BITS)) u_conv (
        .i_func    (r_func),
        .i_operand (r_op),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
        r_func <= t_func'(i_func);
        r_op   <= i_operand;
        r_res  <= n_res;
    end

    assign o_done     = r_out_vld;
    assign o_result   = r_res.result;
    assign o_overflow = r_res.overflow;

    `FFC_ASSERT_IMPL(a_latency, i_clk, i_rst_n, (start && !busy) |=> ##1 o_done, "item lost")
    `FFC_ASSERT_IMPL(a_no_spur, i_clk, i_rst_n, o_done |-> $past(r_in_vld), "spurious result")
    `FFC_ASSERT_IMPL(a_f2f_ovf, i_clk, i_rst_n, (r_in_vld && r_func == FUNC_FIX2FLT) |=> !o_overflow, "fix2flt overflow")
endmodule

[rtl/core/ffc_conv.sv]
// ----------------------------------------------------------------------------
// ffc_conv
// Combinational conversion datapath for all four operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ffc_conv import ffc_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  t_func       i_func,
    input  logic [31:0] i_operand,
    output t_res        o_res
);
    localparam int FB = FRACTION_BITS;

    function automatic t_res pack_signed(input logic neg, input logic [32:0] mag);
        t_res r;
        r.overflow = 1'b0;
        if (neg) begin
            if (mag > 33'h0_8000_0000) begin
                r.result = NEG_SAT;
                r.overflow = 1'b1;
            end else begin
                r.result = 32'(-mag[31:0]);
            end
        end else if (mag > 33'h0_7FFF_FFFF) begin
            r.result = POS_SAT;
            r.overflow = 1'b1;
        end else begin
            r.result = mag[31:0];
        end
        return r;
    endfunction

    logic        neg;
    logic [32:0] mag;
    logic [5:0]  lz;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [24:0] keep;
    logic        rnd_up;
    logic [5:0]  msb;
    logic [23:0] mant;
    logic [32:0] i2f_mag;
    logic [7:0]  exp_f;
    logic [22:0] man_f;
    logic [23:0] m24;
    logic signed [9:0] k;
    logic [32:0] f2x_mag;
    logic [56:0] shl;
    logic [5:0]  n;
    logic [24:0] addv;
    logic [63:0] shr;
    logic [32:0] rint;
    logic [63:0] rwide;
    t_res        r_i2x, r_f2x, r_x2f, r_x2i;

    always_comb begin
        neg = i_operand[31];
        mag = neg ? {1'b0, 32'(-i_operand)} : {1'b0, i_operand};
        if (i_operand == NEG_SAT) mag = 33'h0_8000_0000;

        lz = 6'd32;
        for (int b = 0; b < 33; b++) begin
            if (mag[b]) lz = 6'(b);
        end
        p = lz[4:0];
        msb = lz;
        norm = mag[31:0] << (5'd31 - p);
        rnd_up = 1'b0;
        if (lz > 6'd23) begin
            rnd_up = norm[7] && (norm[6:0] != 7'd0 || norm[8]);
        end
        keep = {1'b0, norm[31:8]} + {24'd0, rnd_up};
        mant = keep[24] ? keep[24:1] : keep[23:0];
        if (keep[24]) msb = lz + 6'd1;

        // int to fixed
        i2f_mag = mag << FB;
        if (FB > 0 && (mag >> (33 - FB)) != 33'd0) i2f_mag = 33'h0_8000_0001;
        r_i2x = pack_signed(neg, i2f_mag);

        // fixed to float
        r_x2f.overflow = 1'b0;
        if (mag == 33'd0) r_x2f.result = 32'd0;
        else r_x2f.result = {neg, 8'(10'(msb) + 10'd127 - 10'(FB)), mant[22:0]};

        // fixed to int
        shl = 57'(mant) << msb;
        rint = (msb >= 6'd23) ? 33'(shl >> 23) : mag;
        rwide = 64'(rint) >> FB;
        r_x2i = pack_signed(neg, rwide[32:0]);
        if (mag == 33'd0) r_x2i = '{result: 32'd0, overflow: 1'b0};

        // float to fixed
        exp_f = i_operand[30:23];
        man_f = i_operand[22:0];
        m24 = (exp_f == 8'd0) ? {1'b0, man_f} : {1'b1, man_f};
        k = (exp_f == 8'd0) ? 10'(-149 + FB) : 10'($signed({2'b0, exp_f}) - 150 + FB);
        f2x_mag = 33'd0;
        n = 6'd0;
        addv = 25'd0;
        shl = '0;
        shr = '0;
        if (k >= 0) begin
            if (m24 != 24'd0 && k > 10'sd32) f2x_mag = 33'h0_8000_0001;
            else begin
                shl = 57'(m24) << k[5:0];
                f2x_mag = (shl[56:33] != 24'd0) ? 33'h1_0000_0000 : shl[32:0];
            end
        end else begin
            if (-k <= 10'sd30) begin
                n = 6'(-k);
                addv = {1'b0, m24} + (25'd1 << (n - 6'd1));
                shr = 64'(addv) >> n;
                f2x_mag = shr[32:0];
            end
        end
        r_f2x = pack_signed(neg, f2x_mag);
        if (exp_f == 8'hFF) begin
            r_f2x.overflow = 1'b1;
            r_f2x.result = (man_f != 23'd0 || !neg) ? POS_SAT : NEG_SAT;
        end

        unique case (i_func)
            FUNC_INT2FIX: o_res = r_i2x;
            FUNC_FLT2FIX: o_res = r_f2x;
            FUNC_FIX2FLT: o_res = r_x2f;
            FUNC_FIX2INT: o_res = r_x2i;
            default:      o_res = r_x2i;
        endcase
    end
endmodule
